>>> rtl/core/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types and constants of the SHA-256 byte stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package sha256_pkg;

  typedef logic [31:0] word_t;

  // Eight 32-bit working or chaining words, element 0 is a / H0.
  typedef logic [7:0][31:0] work_t;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds     = 64;
  localparam int unsigned DigWords   = 8;
  localparam int unsigned LenBytePos = 56;

  localparam logic [7:0] PadByte  = 8'h80;
  localparam logic [7:0] ZeroByte = 8'h00;

  localparam work_t InitHash = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic word_t round_k(input logic [5:0] idx);
    word_t k;
    case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/sha256_if.sv
// ----------------------------------------------------------------------------
// sha256 channel interfaces
// Valid/ready channels for the request (byte or finish) and digest words.
// ----------------------------------------------------------------------------
`default_nettype none

interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last;

  modport source (output valid, output digest_word, output word_index, output last,
                  input ready);
  modport sink   (input valid, input digest_word, input word_index, input last,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/core/sha256_round.sv
// ----------------------------------------------------------------------------
// sha256_round
// One compression round plus one message schedule step, combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_round
  import sha256_pkg::*;
(
  input  wire work_t v_i,
  input  wire word_t k_i,
  input  wire word_t w0_i,   // W[t]
  input  wire word_t w1_i,   // W[t+1]
  input  wire word_t w9_i,   // W[t+9]
  input  wire word_t w14_i,  // W[t+14]
  output work_t v_o,
  output word_t w_new_o // W[t+16]
);

  function automatic word_t ror(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  word_t big0, big1, ch, maj, t1, t2, s0, s1;

  always_comb begin
    big1 = ror(v_i[4], 6) ^ ror(v_i[4], 11) ^ ror(v_i[4], 25);
    ch   = (v_i[4] & v_i[5]) ^ (~v_i[4] & v_i[6]);
    t1   = v_i[7] + big1 + ch + k_i + w0_i;
    big0 = ror(v_i[0], 2) ^ ror(v_i[0], 13) ^ ror(v_i[0], 22);
    maj  = (v_i[0] & v_i[1]) ^ (v_i[0] & v_i[2]) ^ (v_i[1] & v_i[2]);
    t2   = big0 + maj;

    v_o[7] = v_i[6];
    v_o[6] = v_i[5];
    v_o[5] = v_i[4];
    v_o[4] = v_i[3] + t1;
    v_o[3] = v_i[2];
    v_o[2] = v_i[1];
    v_o[1] = v_i[0];
    v_o[0] = t1 + t2;

    s0 = ror(w1_i, 7) ^ ror(w1_i, 18) ^ (w1_i >> 3);
    s1 = ror(w14_i, 17) ^ ror(w14_i, 19) ^ (w14_i >> 10);
    w_new_o = w0_i + s0 + w9_i + s1;
  end

endmodule

`default_nettype wire

>>> rtl/core/sha256_byte_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// SHA-256 over a byte stream, one message byte per request, digest as 8 words.
// ----------------------------------------------------------------------------
// Usage: a data request (op = 0) is taken while the hasher is idle. Every 64th
// data byte completes a block; the hasher then runs the 64 rounds through its
// single round unit, one round per cycle, then folds the result into the
// chaining words, and keeps ready low until the fold is done. A finish request
// (op = 1) feeds the padding through the same byte path, one byte per cycle
// while no block is being compressed: 0x80, zeros up to byte 56 and the 8-byte
// bit length, each full block compressed as above (two blocks when 56 or more
// bytes were pending). The digest then leaves as eight words, H0 first, last
// flagged on word 7, one per accepted output cycle; after word 7 the hasher is
// back at the initial hash values and ready for the next message.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_byte_stream_hasher
  import sha256_pkg::*;
(
  input  wire           clk_i,
  input  wire           rst_ni,
  sha256_in_if.sink     req_i,
  sha256_out_if.source  dig_o
);

  // Sequencer states
  localparam logic [2:0] StIdle  = 3'd0;  // take data / finish requests
  localparam logic [2:0] StPad   = 3'd1;  // push zero pad bytes
  localparam logic [2:0] StLen   = 3'd2;  // push 8 length bytes, MSB first
  localparam logic [2:0] StRound = 3'd3;  // 64 compression rounds
  localparam logic [2:0] StFold  = 3'd4;  // H += working vars
  localparam logic [2:0] StOut   = 3'd5;  // emit digest words

  localparam logic [5:0] LastFill = 6'(BlockBytes - 1);
  localparam logic [5:0] LenFill  = 6'(LenBytePos);
  localparam logic [5:0] LastRnd  = 6'(Rounds - 1);
  localparam logic [2:0] LastWord = 3'(DigWords - 1);

  logic [2:0]   state_q, state_d;
  logic [5:0]   fill_q, fill_d;
  logic [63:0]  len_q, len_d;
  logic         fin_q, fin_d;     // finish in progress
  logic         final_q, final_d; // block holding the length is in flight
  logic [5:0]   rnd_q, rnd_d;
  logic [2:0]   idx_q, idx_d;
  logic [511:0] win_q, win_d;     // block bytes, then schedule window
  work_t        v_q, v_d;
  work_t        h_q, h_d;

  logic         in_acc, out_acc;
  logic         push;
  logic [7:0]   push_byte;
  work_t        v_rnd;
  word_t        w_new;

  assign in_acc  = req_i.valid & req_i.ready;
  assign out_acc = dig_o.valid & dig_o.ready;

  assign req_i.ready       = (state_q == StIdle);
  assign dig_o.valid       = (state_q == StOut);
  assign dig_o.digest_word = h_q[0];
  assign dig_o.word_index  = idx_q;
  assign dig_o.last        = (idx_q == LastWord);

  // Window word 0 is the oldest, i.e. W[t] during the rounds.
  sha256_round u_round (
    .v_i     (v_q),
    .k_i     (round_k(rnd_q)),
    .w0_i    (win_q[511:480]),
    .w1_i    (win_q[479:448]),
    .w9_i    (win_q[223:192]),
    .w14_i   (win_q[63:32]),
    .v_o     (v_rnd),
    .w_new_o (w_new)
  );

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    len_d     = len_q;
    fin_d     = fin_q;
    final_d   = final_q;
    rnd_d     = rnd_q;
    idx_d     = idx_q;
    v_d       = v_q;
    h_d       = h_q;
    push      = 1'b0;
    push_byte = ZeroByte;

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          push = 1'b1;
          if (!req_i.op) begin
            push_byte = req_i.data_byte;
            len_d     = len_q + 64'd8;
          end else begin
            push_byte = PadByte;
            fin_d     = 1'b1;
            state_d   = StPad;
          end
        end
      end
      StPad: begin
        if (fill_q == LenFill) begin
          state_d = StLen;
        end else begin
          push = 1'b1;
        end
      end
      StLen: begin
        push      = 1'b1;
        push_byte = len_q[63:56];
        len_d     = {len_q[55:0], len_q[63:56]};
        if (fill_q == LastFill) begin
          final_d = 1'b1;
        end
      end
      StRound: begin
        v_d   = v_rnd;
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == LastRnd) begin
          state_d = StFold;
        end
      end
      StFold: begin
        for (int i = 0; i < 8; i++) begin
          h_d[i] = h_q[i] + v_q[i];
        end
        if (final_q) begin
          state_d = StOut;
          idx_d   = '0;
        end else if (fin_q) begin
          state_d = StPad;
        end else begin
          state_d = StIdle;
        end
      end
      StOut: begin
        if (out_acc) begin
          h_d   = {h_q[0], h_q[7:1]};
          idx_d = idx_q + 3'd1;
          if (idx_q == LastWord) begin
            h_d     = InitHash;
            len_d   = '0;
            fin_d   = 1'b0;
            final_d = 1'b0;
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // A full block starts the rounds from the current chaining words.
    if (push) begin
      fill_d = fill_q + 6'd1;
      if (fill_q == LastFill) begin
        state_d = StRound;
        v_d     = h_q;
        rnd_d   = '0;
      end
    end
  end

  always_comb begin
    if (push) begin
      win_d = {win_q[503:0], push_byte};
    end else if (state_q == StRound) begin
      win_d = {win_q[479:0], w_new};
    end else begin
      win_d = win_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fill_q  <= '0;
      len_q   <= '0;
      fin_q   <= 1'b0;
      final_q <= 1'b0;
      rnd_q   <= '0;
      idx_q   <= '0;
      h_q     <= InitHash;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      len_q   <= len_d;
      fin_q   <= fin_d;
      final_q <= final_d;
      rnd_q   <= rnd_d;
      idx_q   <= idx_d;
      h_q     <= h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    v_q   <= v_d;
  end

`ifndef ASSERT_OFF
  a_out_block_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dig_o.valid |-> (fill_q == '0 && final_q))
    else $error("digest shown with bytes pending");

  a_len_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StLen) |-> (fill_q[5:3] == 3'b111 && fin_q))
    else $error("length bytes outside last 8 positions");

  a_pad_finishing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StPad) |-> (fin_q && !final_q))
    else $error("padding without finish");

  a_rnd_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StRound) |-> (rnd_q == '0 || rnd_q == LastRnd + 6'd1))
    else $error("round counter off outside rounds");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && dig_o.last) |=> (state_q == StIdle && len_q == '0 && !fin_q))
    else $error("hasher not restarted after digest");
`endif

endmodule

`default_nettype wire
